// File: rtl/esp_pkg.sv
package esp_pkg;

    // input transaction kinds carried in tuser
    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_RESET  = 2'd3
    } action_t;

    // configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RPC      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RATE     = 3'd6;

    localparam logic [15:0] RST_SETPOINT = 16'd0;
    localparam logic [15:0] RST_GAIN_P   = 16'd1280;
    localparam logic [15:0] RST_GAIN_I   = 16'd0;
    localparam logic [15:0] RST_GAIN_D   = 16'd0;
    localparam logic [15:0] RST_RPC      = 16'd4389;
    localparam logic [15:0] RST_PERIOD   = 16'd410;
    localparam logic [15:0] RST_RATE     = 16'd160;

    localparam logic signed [15:0] S16_MAX = 16'sh7fff;
    localparam logic signed [15:0] S16_MIN = 16'sh8000;

    // multiplier operand b: 16-bit config value widened to signed
    localparam int MUL_BW = 17;

    localparam int SPEED_SHIFT = 8;
    localparam int ITG_SHIFT   = 4;
    localparam int P_SHIFT     = 8;
    localparam int D_SHIFT     = 4;
    localparam int U_FRAC      = 20;

    localparam int DIFF_W    = 17;
    localparam int DERIV_W   = 33;
    localparam int ITG_W     = 20;
    localparam int ITG_INC_W = 29;
    localparam int ITG_SUM_W = 30;
    localparam logic signed [ITG_SUM_W-1:0] ITG_MAX = 30'sd409600;
    localparam logic signed [ITG_SUM_W-1:0] ITG_MIN = -30'sd409600;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;

    // decoder controls from the sequencer
    typedef struct packed {
        logic sample;
        logic clear;
        logic phase_a;
        logic phase_b;
    } dec_ctrl_t;

endpackage

// File: rtl/esp_decoder.sv
module esp_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  esp_pkg::dec_ctrl_t            ctrl,
    output logic signed [COUNT_WIDTH-1:0] count
);
    import esp_pkg::*;

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic signed [COUNT_WIDTH-1:0] count_reg;
    logic signed [COUNT_WIDTH-1:0] count_next;
    logic                          prev_a_reg;
    logic                          prev_a_next;
    logic                          prev_b_reg;
    logic                          prev_b_next;
    logic                          step_up;
    logic                          step_dn;

    always_comb
    begin
        step_up     = 1'b0;
        step_dn     = 1'b0;
        prev_a_next = prev_a_reg;
        prev_b_next = prev_b_reg;
        // channel a has priority over channel b
        if (ctrl.phase_a != prev_a_reg)
        begin
            step_up     = (ctrl.phase_a == ctrl.phase_b);
            step_dn     = (ctrl.phase_a != ctrl.phase_b);
            prev_a_next = ctrl.phase_a;
        end
        else if (ctrl.phase_b != prev_b_reg)
        begin
            step_up     = (ctrl.phase_a != ctrl.phase_b);
            step_dn     = (ctrl.phase_a == ctrl.phase_b);
            prev_b_next = ctrl.phase_b;
        end
        count_next = count_reg;
        if (step_up && count_reg != CNT_MAX)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        else if (step_dn && count_reg != CNT_MIN)
        begin
            count_next = count_reg - COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            prev_a_reg <= 1'b0;
            prev_b_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            count_reg <= '0;
        end
        else if (ctrl.sample)
        begin
            count_reg  <= count_next;
            prev_a_reg <= prev_a_next;
            prev_b_reg <= prev_b_next;
        end
    end

    assign count = count_reg;

endmodule

// File: rtl/esp_serial_mul.sv
module esp_serial_mul #(
    parameter int A_WIDTH = 33,
    parameter int B_WIDTH = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [A_WIDTH-1:0]           a,
    input  logic signed [B_WIDTH-1:0]           b,
    output logic                                done,
    output logic signed [A_WIDTH+B_WIDTH-1:0]   product
);
    import esp_pkg::*;

    localparam int STEP_W = (B_WIDTH > 1) ? $clog2(B_WIDTH) : 1;

    logic signed [A_WIDTH-1:0] a_reg;
    logic signed [A_WIDTH:0]   hi_reg;
    logic        [B_WIDTH-1:0] lo_reg;
    logic        [STEP_W-1:0]  step_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [A_WIDTH:0]   addend;
    logic signed [A_WIDTH:0]   sum;
    logic                      last_step;

    // one multiplier bit per cycle, lsb first; the sign bit of b subtracts
    always_comb
    begin
        addend    = {a_reg[A_WIDTH-1], a_reg};
        last_step = (step_reg == STEP_W'(B_WIDTH - 1));
        if (!lo_reg[0])
        begin
            sum = hi_reg;
        end
        else if (last_step)
        begin
            sum = hi_reg - addend;
        end
        else
        begin
            sum = hi_reg + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[A_WIDTH], sum[A_WIDTH:1]};
            lo_reg <= {sum[0], lo_reg[B_WIDTH-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg[A_WIDTH-1:0], lo_reg};

endmodule

// File: rtl/encoder_speed_pid.sv
// encoder_speed_pid: quadrature decoder with a fixed-point speed pid loop
// pin sample, clear integral and full reset transactions finish without leaving idle
// a control tick raises its result after six products run in turn on one shift-add
// multiplier that retires one multiplier bit per cycle
// the block takes a new input while a result waits in the output register
// rst_n is asynchronous, active low: config returns to defaults, state clears
module encoder_speed_pid #(
    parameter int COUNT_WIDTH = 16,
    parameter int DRIVE_LIMIT = 255
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] phase_a, [1] phase_b
    input  logic [esp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] action
    input  logic [esp_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] speed_rpm, [31:16] error_rpm, [39:32] drive_level, [40] drive_reverse
    output logic [esp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [esp_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data
);
    import esp_pkg::*;

    localparam int MUL_AW = (COUNT_WIDTH > DERIV_W) ? COUNT_WIDTH : DERIV_W;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int ACC_W  = MUL_PW + 6;
    localparam logic signed [ACC_W-1:0] U_LIMIT = ACC_W'(DRIVE_LIMIT) << U_FRAC;
    localparam logic signed [ACC_W-1:0] U_NEG   = -U_LIMIT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPEED,
        S_ERR,
        S_ITG,
        S_DIFF,
        S_PROP,
        S_INTG,
        S_DERV,
        S_CLAMP,
        S_OUT
    } state_t;

    state_t state_reg;

    logic signed [15:0] setpoint_reg;
    logic signed [15:0] gain_p_reg;
    logic signed [15:0] gain_i_reg;
    logic signed [15:0] gain_d_reg;
    logic        [15:0] rpc_reg;
    logic        [15:0] period_reg;
    logic        [15:0] rate_reg;

    logic signed [15:0]            speed_reg;
    logic signed [15:0]            err_reg;
    logic signed [15:0]            last_err_reg;
    logic signed [ITG_W-1:0]       integral_reg;
    logic signed [ITG_INC_W-1:0]   itg_inc_reg;
    logic signed [DERIV_W-1:0]     deriv_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       u_reg;
    logic                          m_valid_reg;
    logic        [OUT_DATA_W-1:0]  m_data_reg;

    logic                          in_accept;
    action_t                       action;
    dec_ctrl_t                     dec_ctrl;
    logic signed [COUNT_WIDTH-1:0] dec_count;

    logic                          mul_start;
    logic signed [MUL_AW-1:0]      mul_a;
    logic signed [MUL_BW-1:0]      mul_b;
    logic                          mul_done;
    logic signed [MUL_PW-1:0]      prod;

    logic signed [MUL_PW-1:0]      speed_rnd;
    logic signed [15:0]            speed_sat;
    logic signed [DIFF_W-1:0]      err_diff;
    logic signed [15:0]            err_sat;
    logic signed [MUL_PW-1:0]      itg_rnd;
    logic signed [ITG_SUM_W-1:0]   itg_total;
    logic signed [ITG_W-1:0]       itg_next;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       u_clamped;
    logic        [ACC_W-1:0]       mag;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign action        = action_t'(s_axis_tuser);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign dec_ctrl.sample  = in_accept && (action == ACT_SAMPLE);
    assign dec_ctrl.clear   = in_accept && (action == ACT_TICK || action == ACT_RESET);
    assign dec_ctrl.phase_a = s_axis_tdata[0];
    assign dec_ctrl.phase_b = s_axis_tdata[1];

    esp_decoder #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_decoder (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (dec_ctrl),
        .count(dec_count)
    );

    esp_serial_mul #(
        .A_WIDTH(MUL_AW),
        .B_WIDTH(MUL_BW)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .product(prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= RST_SETPOINT;
            gain_p_reg   <= RST_GAIN_P;
            gain_i_reg   <= RST_GAIN_I;
            gain_d_reg   <= RST_GAIN_D;
            rpc_reg      <= RST_RPC;
            period_reg   <= RST_PERIOD;
            rate_reg     <= RST_RATE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SETPOINT: setpoint_reg <= cfg_data;
                REG_GAIN_P:   gain_p_reg   <= cfg_data;
                REG_GAIN_I:   gain_i_reg   <= cfg_data;
                REG_GAIN_D:   gain_d_reg   <= cfg_data;
                REG_RPC:      rpc_reg      <= cfg_data;
                REG_PERIOD:   period_reg   <= cfg_data;
                REG_RATE:     rate_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // datapath around the shared multiplier
    always_comb
    begin
        speed_rnd = (prod + (MUL_PW'(1) << (SPEED_SHIFT - 1))) >>> SPEED_SHIFT;
        if ((&speed_rnd[MUL_PW-1:15]) || !(|speed_rnd[MUL_PW-1:15]))
        begin
            speed_sat = speed_rnd[15:0];
        end
        else
        begin
            speed_sat = speed_rnd[MUL_PW-1] ? S16_MIN : S16_MAX;
        end

        err_diff = DIFF_W'(setpoint_reg) - DIFF_W'(speed_reg);
        if (err_diff[DIFF_W-1] == err_diff[15])
        begin
            err_sat = err_diff[15:0];
        end
        else
        begin
            err_sat = err_diff[DIFF_W-1] ? S16_MIN : S16_MAX;
        end

        itg_rnd   = (prod + (MUL_PW'(1) << (ITG_SHIFT - 1))) >>> ITG_SHIFT;
        itg_total = ITG_SUM_W'(integral_reg) + ITG_SUM_W'(itg_inc_reg);
        if (itg_total > ITG_MAX)
        begin
            itg_next = ITG_MAX[ITG_W-1:0];
        end
        else if (itg_total < ITG_MIN)
        begin
            itg_next = ITG_MIN[ITG_W-1:0];
        end
        else
        begin
            itg_next = itg_total[ITG_W-1:0];
        end

        diff     = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);
        prod_ext = ACC_W'(prod);

        if (acc_reg > U_LIMIT)
        begin
            u_clamped = U_LIMIT;
        end
        else if (acc_reg < U_NEG)
        begin
            u_clamped = U_NEG;
        end
        else
        begin
            u_clamped = acc_reg;
        end
        mag = u_reg[ACC_W-1] ? -u_reg : u_reg;
    end

    // from S_ITG on, each product launches in the cycle the previous one completes
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = MUL_AW'(dec_count);
        mul_b     = {1'b0, rpc_reg};
        case (state_reg)
            S_IDLE:
            begin
                mul_start = in_accept && (action == ACT_TICK);
            end
            S_ERR:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_AW'(err_sat);
                mul_b     = {1'b0, period_reg};
            end
            S_ITG:
            begin
                mul_start = mul_done;
                mul_a     = MUL_AW'(diff);
                mul_b     = {1'b0, rate_reg};
            end
            S_DIFF:
            begin
                mul_start = mul_done;
                mul_a     = MUL_AW'(err_reg);
                mul_b     = {gain_p_reg[15], gain_p_reg};
            end
            S_PROP:
            begin
                mul_start = mul_done;
                mul_a     = MUL_AW'(integral_reg);
                mul_b     = {gain_i_reg[15], gain_i_reg};
            end
            S_INTG:
            begin
                mul_start = mul_done;
                mul_a     = MUL_AW'(deriv_reg);
                mul_b     = {gain_d_reg[15], gain_d_reg};
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            speed_reg    <= '0;
            err_reg      <= '0;
            last_err_reg <= '0;
            integral_reg <= '0;
            itg_inc_reg  <= '0;
            deriv_reg    <= '0;
            acc_reg      <= '0;
            u_reg        <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && state_reg != S_OUT)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (action)
                            ACT_TICK:
                            begin
                                state_reg <= S_SPEED;
                            end
                            ACT_CLEAR:
                            begin
                                integral_reg <= '0;
                            end
                            ACT_RESET:
                            begin
                                integral_reg <= '0;
                                last_err_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SPEED:
                begin
                    if (mul_done)
                    begin
                        speed_reg <= speed_sat;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg   <= err_sat;
                    state_reg <= S_ITG;
                end
                S_ITG:
                begin
                    if (mul_done)
                    begin
                        itg_inc_reg <= itg_rnd[ITG_INC_W-1:0];
                        state_reg   <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    if (mul_done)
                    begin
                        deriv_reg    <= prod[DERIV_W-1:0];
                        last_err_reg <= err_reg;
                        integral_reg <= itg_next;
                        state_reg    <= S_PROP;
                    end
                end
                S_PROP:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= prod_ext <<< P_SHIFT;
                        state_reg <= S_INTG;
                    end
                end
                S_INTG:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= acc_reg + prod_ext;
                        state_reg <= S_DERV;
                    end
                end
                S_DERV:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= acc_reg + (prod_ext <<< D_SHIFT);
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP:
                begin
                    u_reg     <= u_clamped;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {7'd0, u_reg[ACC_W-1], mag[U_FRAC+7:U_FRAC],
                                        err_reg, speed_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_SPEED || state_reg == S_ITG || state_reg == S_DIFF ||
                      state_reg == S_PROP || state_reg == S_INTG || state_reg == S_DERV))
        else $error("multiplier finished outside a wait state");

    a_itg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ITG_SUM_W'(integral_reg) <= ITG_MAX) && (ITG_SUM_W'(integral_reg) >= ITG_MIN))
        else $error("integral outside its clamp");

    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && action == ACT_TICK) |=> (state_reg == S_SPEED && dec_count == '0))
        else $error("tick did not start the sequence or clear the count");

endmodule
